// ===== design/pte_pkg.sv =====
// Shared types, field widths and codes for the particle table core.
package pte_pkg;

	localparam int SLOT_W = 6;
	localparam int CNT_W  = 7;
	localparam int POS_W  = 24;
	localparam int VEL_W  = 20;
	localparam int DT_W   = 16;
	localparam int SPD_W  = 11;
	localparam int LIM_W  = 19;
	localparam int SQ_W   = 40;
	localparam int ROOT_W = 20;
	localparam int QUO_W  = 19;

	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_STEP   = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	localparam logic [2:0] KIND_CREATED = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_STEP    = 3'd2;
	localparam logic [2:0] KIND_READ    = 3'd3;
	localparam logic [2:0] KIND_CLEARED = 3'd4;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BOUNDS = 2'd2;
	localparam logic [1:0] REG_SPEED  = 2'd3;

	localparam logic DIV_X = 1'b0;
	localparam logic DIV_Y = 1'b1;

	typedef struct packed {
		logic [1:0]              mode;
		logic [SLOT_W-1:0]       slot_id;
		logic [POS_W-1:0]        start_x;
		logic [POS_W-1:0]        start_y;
		logic signed [VEL_W-1:0] start_vx;
		logic signed [VEL_W-1:0] start_vy;
		logic [DT_W-1:0]         time_step;
	} in_t;

	typedef struct packed {
		logic [2:0]              kind;
		logic [SLOT_W-1:0]       slot;
		logic                    is_active;
		logic [POS_W-1:0]        x_pos;
		logic [POS_W-1:0]        y_pos;
		logic signed [VEL_W-1:0] x_vel;
		logic signed [VEL_W-1:0] y_vel;
		logic [CNT_W-1:0]        live_count;
		logic                    last;
	} out_t;

	typedef struct packed {
		logic              take_in;
		logic              load_in;
		logic              load_mem;
		logic              mul;
		logic              move;
		logic              sq;
		logic              root_start;
		logic              div_start;
		logic              div_sel;
		logic              wb;
		logic              set_live;
		logic              clr_all;
		logic              emit;
		logic [2:0]        kind;
		logic [SLOT_W-1:0] slot;
		logic              active;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic live;
		logic over;
		logic root_done;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ===== design/pte_root.sv =====
// Iterative ceiling square root, two radicand bits per cycle.
module pte_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pte_pkg::SQ_W-1:0]    n,
	output logic                        done,
	output logic [pte_pkg::ROOT_W-1:0]  s
);
	import pte_pkg::*;

	localparam logic [SQ_W-1:0] BIT_TOP = SQ_W'(1) << (SQ_W - 2);

	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] x_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;
	logic            ge;

	assign trial = r_q + bit_q;
	assign ge    = x_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= n;
			r_q   <= '0;
			bit_q <= BIT_TOP;
		end else if (busy_q) begin
			if (ge) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// A nonzero remainder means the floor root falls short of the ceiling.
	assign s    = r_q[ROOT_W-1:0] + ROOT_W'(|x_q);
	assign done = done_q;

endmodule

// ===== design/pte_div.sv =====
// Iterative divider for the speed limit: q = m * lim / s, one quotient bit per cycle.
module pte_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pte_pkg::VEL_W-1:0]   m,
	input  logic [pte_pkg::LIM_W-1:0]   lim,
	input  logic [pte_pkg::ROOT_W-1:0]  s,
	output logic                        done,
	output logic [pte_pkg::QUO_W-1:0]   q
);
	import pte_pkg::*;

	localparam int PROD_W = VEL_W + LIM_W;

	logic              busy_q;
	logic              mul_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [VEL_W-1:0]  m_q;
	logic [LIM_W-1:0]  lim_q;
	logic [ROOT_W-1:0] s_q;
	logic [ROOT_W-1:0] rem_q;
	logic [QUO_W-1:0]  lo_q;
	logic [QUO_W-1:0]  q_q;
	logic [PROD_W-1:0] prod;
	logic [ROOT_W:0]   rem2;
	logic              ge;

	assign prod = m_q * lim_q;
	assign rem2 = {rem_q, lo_q[QUO_W-1]};
	assign ge   = rem2 >= {1'b0, s_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mul_q  <= 1'b1;
			end else if (mul_q) begin
				mul_q <= 1'b0;
				cnt_q <= 5'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient never exceeds lim, so the top part of the product is
	// already below the divisor and seeds the remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= m;
			lim_q <= lim;
			s_q   <= s;
		end else if (mul_q) begin
			rem_q <= prod[PROD_W-1:QUO_W];
			lo_q  <= prod[QUO_W-1:0];
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= ROOT_W'(rem2 - {1'b0, s_q});
			end else begin
				rem_q <= rem2[ROOT_W-1:0];
			end
			lo_q <= lo_q << 1;
			q_q  <= {q_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

// ===== design/pte_dp.sv =====
// Datapath: register file, particle memory, live flags, Euler update and output register.
module pte_dp #(
	parameter int SLOT_COUNT = 64,
	parameter int IDX_W      = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  pte_pkg::in_t         in_data,
	input  pte_pkg::cmd_t        cmd,
	input  logic [IDX_W-1:0]     addr,
	output pte_pkg::sts_t        sts,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pte_pkg::out_t        out_data
);
	import pte_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        py;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
	} ent_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos;
		logic signed [VEL_W-1:0] vel;
	} mv_t;

	localparam int PROD_W = VEL_W + DT_W + 1;

	logic [15:0]      width_q;
	logic [15:0]      height_q;
	logic             bnd_q;
	logic [SPD_W-1:0] spd_q;

	in_t                     in_q;
	ent_t                    mem [SLOT_COUNT];
	ent_t                    rd_q;
	logic [SLOT_COUNT-1:0]   live_q;
	logic [CNT_W-1:0]        total_q;
	logic [POS_W-1:0]        px_q;
	logic [POS_W-1:0]        py_q;
	logic signed [VEL_W-1:0] vx_q;
	logic signed [VEL_W-1:0] vy_q;
	logic signed [PROD_W-1:0] prodx_q;
	logic signed [PROD_W-1:0] prody_q;
	logic [SQ_W-1:0]         sqx_q;
	logic [SQ_W-1:0]         sqy_q;
	logic [2*LIM_W-1:0]      lim2_q;
	logic signed [SQ_W-1:0]  sqx_w;
	logic signed [SQ_W-1:0]  sqy_w;
	logic [SQ_W-1:0]         sum_w;
	logic [LIM_W-1:0]        lim;
	logic                    sel_q;
	logic                    out_valid_q;
	out_t                    out_q;
	logic                    out_free;
	logic                    wr_en;
	mv_t                     mvx;
	mv_t                     mvy;
	logic [ROOT_W-1:0]       root_s;
	logic                    root_done;
	logic                    div_done;
	logic [QUO_W-1:0]        quo;
	logic [VEL_W-1:0]        div_m;
	logic signed [VEL_W-1:0] div_v;
	logic signed [VEL_W-1:0] quo_v;

	function automatic mv_t move_axis(
		input logic [POS_W-1:0]        p,
		input logic signed [VEL_W-1:0] v,
		input logic signed [PROD_W-1:0] prod,
		input logic [15:0]             wall,
		input logic                    en
	);
		logic signed [PROD_W-17:0] delta;
		logic signed [POS_W+1:0]   np;
		logic signed [POS_W+1:0]   top;
		logic signed [VEL_W-1:0]   hv;
		mv_t                       r;
		// Dropping the low 16 bits of a signed product rounds toward minus infinity.
		delta = $signed(prod[PROD_W-1:16]);
		np    = $signed({2'b00, p}) + (POS_W+2)'(delta);
		top   = $signed({2'b00, wall, 8'h00});
		hv    = v >>> 1;
		r.vel = v;
		if (en) begin
			if (np < 0) begin
				r.pos = '0;
				r.vel = -hv;
			end else if (np > top) begin
				r.pos = top[POS_W-1:0];
				r.vel = -hv;
			end else begin
				r.pos = np[POS_W-1:0];
			end
		end else begin
			if (np < 0) begin
				r.pos = '0;
			end else if (np[POS_W+1:POS_W] != 2'b00) begin
				r.pos = '1;
			end else begin
				r.pos = np[POS_W-1:0];
			end
		end
		return r;
	endfunction

	// Configuration registers.
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd800;
			height_q <= 16'd600;
			bnd_q    <= 1'b1;
			spd_q    <= 11'd100;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[15:0];
				REG_HEIGHT: height_q <= pwdata[15:0];
				REG_BOUNDS: bnd_q    <= pwdata[0];
				REG_SPEED:  spd_q    <= pwdata[SPD_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = {16'd0, width_q};
			REG_HEIGHT: prdata = {16'd0, height_q};
			REG_BOUNDS: prdata = {31'd0, bnd_q};
			REG_SPEED:  prdata = {21'd0, spd_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			in_q <= in_data;
		end
	end

	// Particle memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			mem[addr] <= '{px: px_q, py: py_q, vx: vx_q, vy: vy_q};
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			total_q <= '0;
		end else if (cmd.clr_all) begin
			live_q  <= '0;
			total_q <= '0;
		end else if (cmd.set_live) begin
			live_q[addr] <= 1'b1;
			total_q      <= total_q + CNT_W'(1);
		end
	end

	// Arithmetic.
	assign lim   = {spd_q, 8'h00};
	assign sqx_w = vx_q * vx_q;
	assign sqy_w = vy_q * vy_q;
	assign sum_w = sqx_q + sqy_q;
	assign mvx   = move_axis(px_q, vx_q, prodx_q, width_q, bnd_q);
	assign mvy   = move_axis(py_q, vy_q, prody_q, height_q, bnd_q);
	assign div_v = (cmd.div_sel == DIV_Y) ? vy_q : vx_q;
	assign div_m = div_v[VEL_W-1] ? unsigned'(-div_v) : unsigned'(div_v);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prodx_q <= vx_q * $signed({1'b0, in_q.time_step});
			prody_q <= vy_q * $signed({1'b0, in_q.time_step});
		end
		if (cmd.sq) begin
			sqx_q  <= unsigned'(sqx_w);
			sqy_q  <= unsigned'(sqy_w);
			lim2_q <= lim * lim;
		end
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
	end

	pte_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.n      (sum_w),
		.done   (root_done),
		.s      (root_s)
	);

	pte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.m      (div_m),
		.lim    (lim),
		.s      (root_s),
		.done   (div_done),
		.q      (quo)
	);

	assign quo_v = $signed({1'b0, quo});

	always_ff @(posedge clk) begin
		priority if (cmd.load_in) begin
			px_q <= in_q.start_x;
			py_q <= in_q.start_y;
			vx_q <= in_q.start_vx;
			vy_q <= in_q.start_vy;
		end else if (cmd.load_mem) begin
			px_q <= rd_q.px;
			py_q <= rd_q.py;
			vx_q <= rd_q.vx;
			vy_q <= rd_q.vy;
		end else if (cmd.move) begin
			px_q <= mvx.pos;
			py_q <= mvy.pos;
			vx_q <= mvx.vel;
			vy_q <= mvy.vel;
		end else if (div_done) begin
			if (sel_q == DIV_Y) begin
				vy_q <= vy_q[VEL_W-1] ? -quo_v : quo_v;
			end else begin
				vx_q <= vx_q[VEL_W-1] ? -quo_v : quo_v;
			end
		end
	end

	// Output register.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			out_q.kind       <= cmd.kind;
			out_q.slot       <= cmd.slot;
			out_q.is_active  <= cmd.active;
			out_q.x_pos      <= cmd.active ? px_q : '0;
			out_q.y_pos      <= cmd.active ? py_q : '0;
			out_q.x_vel      <= cmd.active ? vx_q : '0;
			out_q.y_vel      <= cmd.active ? vy_q : '0;
			out_q.live_count <= total_q;
			out_q.last       <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign sts.live      = live_q[addr];
	assign sts.over      = sum_w > SQ_W'(lim2_q);
	assign sts.root_done = root_done;
	assign sts.div_done  = div_done;
	assign sts.out_free  = out_free;

	a_total_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		SLOT_COUNT'($countones(live_q)) == SLOT_COUNT'(total_q))
		else $error("live count disagrees with live flags");

	a_claim_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_live |-> !live_q[addr])
		else $error("create claimed a slot that is already live");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(root_done && div_done))
		else $error("root and divider finished together");

endmodule

// ===== design/pte_ctrl.sv =====
// Controller: sequences create scans, per-slot Euler steps, reads, clears and result words.
module pte_ctrl #(
	parameter int SLOT_COUNT = 64,
	parameter int IDX_W      = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [pte_pkg::SLOT_W-1:0] slot_id,
	output pte_pkg::cmd_t              cmd,
	output logic [IDX_W-1:0]           addr,
	input  pte_pkg::sts_t              sts
);
	import pte_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_LD   = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_MOVE = 4'd5;
	localparam logic [3:0] S_SQ   = 4'd6;
	localparam logic [3:0] S_CMP  = 4'd7;
	localparam logic [3:0] S_ROOT = 4'd8;
	localparam logic [3:0] S_DIVX = 4'd9;
	localparam logic [3:0] S_DIVY = 4'd10;
	localparam logic [3:0] S_WB   = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SLOT_COUNT - 1);

	logic [3:0]       state_q, state_d;
	logic [1:0]       mode_q, mode_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [2:0]       kind_q, kind_d;
	logic             act_q, act_d;
	logic             accept;
	logic             in_range;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;
	assign addr     = cnt_q[IDX_W-1:0];
	assign in_range = cnt_q < CNT_W'(SLOT_COUNT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		kind_d  = kind_q;
		act_d   = act_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.take_in = 1'b1;
					mode_d      = mode;
					cnt_d       = '0;
					unique case (mode)
						MODE_CREATE: state_d = S_SCAN;
						MODE_STEP:   state_d = S_RD;
						MODE_READ: begin
							cnt_d   = CNT_W'(slot_id);
							state_d = S_RD;
						end
						MODE_CLEAR: begin
							cmd.clr_all = 1'b1;
							kind_d      = KIND_CLEARED;
							act_d       = 1'b0;
							state_d     = S_EMIT;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!sts.live) begin
					cmd.load_in  = 1'b1;
					cmd.set_live = 1'b1;
					kind_d       = KIND_CREATED;
					act_d        = 1'b1;
					state_d      = S_WB;
				end else if (cnt_q == LAST_IDX) begin
					kind_d  = KIND_FULL;
					act_d   = 1'b0;
					state_d = S_EMIT;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_RD: begin
				kind_d = (mode_q == MODE_STEP) ? KIND_STEP : KIND_READ;
				if (in_range && sts.live) begin
					act_d   = 1'b1;
					state_d = S_LD;
				end else begin
					act_d   = 1'b0;
					state_d = S_EMIT;
				end
			end
			S_LD: begin
				cmd.load_mem = 1'b1;
				state_d      = (mode_q == MODE_STEP) ? S_MUL : S_EMIT;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_MOVE;
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				state_d  = S_SQ;
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.over) begin
					cmd.root_start = 1'b1;
					state_d        = S_ROOT;
				end else begin
					state_d = S_WB;
				end
			end
			S_ROOT: begin
				if (sts.root_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_X;
					state_d       = S_DIVX;
				end
			end
			S_DIVX: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_Y;
					state_d       = S_DIVY;
				end
			end
			S_DIVY: begin
				if (sts.div_done) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit   = 1'b1;
				cmd.kind   = kind_q;
				cmd.active = act_q;
				cmd.slot   = (kind_q == KIND_FULL || kind_q == KIND_CLEARED) ?
					'0 : cnt_q[SLOT_W-1:0];
				cmd.last   = (mode_q != MODE_STEP) || (cnt_q == LAST_IDX);
				if (sts.out_free) begin
					if (mode_q == MODE_STEP && cnt_q != LAST_IDX) begin
						cnt_d   = cnt_q + CNT_W'(1);
						state_d = S_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_CREATE;
			cnt_q   <= '0;
			kind_q  <= KIND_CREATED;
			act_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			kind_q  <= kind_d;
			act_q   <= act_d;
		end
	end

endmodule

// ===== design/particle_table_euler_step_core.sv =====
// A create scans slots from 0 until one is free or the table is full, then emits one word; a read
// and a clear each emit one word. A step emits a word for every slot in turn; an active slot over
// the speed limit also runs the square root and the two divides. Each word waits for a free output.
// One item is in progress at a time; the next is taken once the last word is in the output register.
// Reset clears live flags and count and restores register defaults; the particle memory is
// left as is and holds no meaning until a slot is created.
module particle_table_euler_step_core #(
	parameter int SLOT_COUNT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  pte_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output pte_pkg::out_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import pte_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	cmd_t             cmd;
	sts_t             sts;
	logic [IDX_W-1:0] addr;

	pte_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (in_data.mode),
		.slot_id  (in_data.slot_id),
		.cmd      (cmd),
		.addr     (addr),
		.sts      (sts)
	);

	pte_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_data   (in_data),
		.cmd       (cmd),
		.addr      (addr),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
